// ----- hdl/uets_pkg.sv -----
// Shared types, constants and the descriptor arming function of the endpoint transfer sequencer.
package uets_pkg;

    localparam int unsigned ITEM_W = 67;
    localparam int unsigned RES_W  = 63;
    localparam int unsigned S_DATA_W = 72;
    localparam int unsigned M_DATA_W = 64;

    localparam logic [6:0] MAX_PACKET    = 7'd64;
    localparam logic [15:0] EP0_RX_LENGTH = 16'd64;
    localparam logic [9:0] SETUP_LENGTH  = 10'd8;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_DONE  = 2'd1;
    localparam logic [1:0] FUNC_ABORT = 2'd2;

    localparam logic [3:0] PID_OUT   = 4'd1;
    localparam logic [3:0] PID_IN    = 4'd9;
    localparam logic [3:0] PID_SETUP = 4'd13;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_NO_BUFFER = 2'd1;
    localparam logic [1:0] ERR_BUSY      = 2'd2;
    localparam logic [1:0] ERR_BAD_PID   = 2'd3;

    localparam logic [1:0] CFG_RX_MAX_PACKET      = 2'd0;
    localparam logic [1:0] CFG_CONTROL_ENDPOINT   = 2'd1;
    localparam logic [1:0] CFG_CONTROL_RX_ADDRESS = 2'd2;

    localparam logic DIR_RX = 1'b0;
    localparam logic DIR_TX = 1'b1;

    // Last member sits in the lowest bits, matching the tdata layout.
    typedef struct packed {
        logic [1:0]  func;
        logic [9:0]  byte_count;
        logic [3:0]  token_pid;
        logic        zlp_request;
        logic [31:0] buffer_address;
        logic        data_toggle;
        logic [15:0] length;
        logic [1:0]  slot_code;
        logic        direction;
    } item_t;

    typedef struct packed {
        logic [1:0]  error_code;
        logic        setup_received;
        logic [15:0] bytes_done;
        logic        transfer_complete;
        logic        arm_toggle;
        logic [31:0] arm_address;
        logic [6:0]  arm_count;
        logic        arm_slot;
        logic        arm_direction;
        logic        arm_valid;
    } result_t;

    typedef struct packed {
        logic [6:0]  rx_max_packet;
        logic        control_endpoint;
        logic [31:0] control_rx_address;
    } cfg_t;

    typedef struct packed {
        logic        pingpong_index;
        logic        toggle_bit;
        logic [15:0] bytes_left;
        logic [15:0] bytes_moved;
        logic        zlp_pending;
        logic        buffer_set;
        logic [31:0] buffer_base;
        logic [1:0]  descriptor_owned;
    } dir_state_t;

    typedef struct packed {
        logic [1:0]  err;
        logic        slot;
        logic [6:0]  count;
        logic [31:0] address;
        logic        toggle;
    } arm_t;

    // Picks the preferred ping-pong slot, or the other one if that is busy.
    function automatic arm_t try_arm(input dir_state_t s);
        arm_t a;
        logic slot;
        a = '0;
        slot = s.pingpong_index;
        if (s.descriptor_owned[slot])
        begin
            slot = ~slot;
        end
        if (!s.buffer_set)
        begin
            a.err = ERR_NO_BUFFER;
        end
        else if (s.descriptor_owned[slot])
        begin
            a.err = ERR_BUSY;
        end
        else
        begin
            a.err     = ERR_NONE;
            a.slot    = slot;
            a.count   = (s.bytes_left < {9'd0, MAX_PACKET}) ? s.bytes_left[6:0] : MAX_PACKET;
            a.address = s.buffer_base + {16'd0, s.bytes_moved};
            a.toggle  = s.toggle_bit;
        end
        return a;
    endfunction

endpackage

// ----- hdl/uets_engine.sv -----
// Per-direction transfer state and the single-pass step logic for one item.
module uets_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  uets_pkg::item_t  item,
    input  uets_pkg::cfg_t   cfg,
    output uets_pkg::result_t result
);
    import uets_pkg::*;

    dir_state_t st_reg [2];
    dir_state_t st_next [2];

    logic       arm_req;
    logic       arm_dir;
    logic       sd;
    arm_t       arm;
    logic [15:0] bytes;

    always_comb
    begin
        st_next[0] = st_reg[0];
        st_next[1] = st_reg[1];
        result = '0;
        arm_req = 1'b0;
        arm_dir = item.direction;
        sd = item.slot_code[1];
        bytes = '0;
        arm = '0;

        case (item.func)
            FUNC_START:
            begin
                st_next[item.direction].buffer_base = item.buffer_address;
                st_next[item.direction].buffer_set  = 1'b1;
                st_next[item.direction].bytes_left  = item.length;
                st_next[item.direction].bytes_moved = '0;
                st_next[item.direction].toggle_bit  = item.data_toggle;
                st_next[item.direction].zlp_pending = item.direction & item.zlp_request;
                arm_req = 1'b1;
                arm_dir = item.direction;
            end
            FUNC_DONE:
            begin
                st_next[sd].descriptor_owned[item.slot_code[0]] = 1'b0;
                st_next[sd].pingpong_index = ~st_reg[sd].pingpong_index;
                st_next[sd].toggle_bit     = ~st_reg[sd].toggle_bit;
                bytes = st_reg[sd].bytes_moved;
                if (item.token_pid == PID_IN)
                begin
                    st_next[DIR_TX].bytes_moved = st_reg[DIR_TX].bytes_moved
                                                  + {6'd0, item.byte_count};
                    st_next[DIR_TX].bytes_left =
                        ({6'd0, item.byte_count} > st_reg[DIR_TX].bytes_left) ? 16'd0
                        : st_reg[DIR_TX].bytes_left - {6'd0, item.byte_count};
                    bytes = st_next[DIR_TX].bytes_moved;
                    arm_dir = DIR_TX;
                    if (st_next[DIR_TX].bytes_left != 16'd0)
                    begin
                        arm_req = 1'b1;
                    end
                    else if (st_reg[DIR_TX].zlp_pending)
                    begin
                        st_next[DIR_TX].zlp_pending = 1'b0;
                        arm_req = 1'b1;
                    end
                    else
                    begin
                        result.transfer_complete = 1'b1;
                    end
                end
                else if (item.token_pid == PID_OUT)
                begin
                    st_next[DIR_RX].bytes_moved = st_reg[DIR_RX].bytes_moved
                                                  + {6'd0, item.byte_count};
                    if (item.byte_count == 10'd0
                        || {6'd0, item.byte_count} > st_reg[DIR_RX].bytes_left
                        || item.byte_count < {3'd0, cfg.rx_max_packet})
                    begin
                        st_next[DIR_RX].bytes_left = '0;
                    end
                    else
                    begin
                        st_next[DIR_RX].bytes_left = st_reg[DIR_RX].bytes_left
                                                     - {6'd0, item.byte_count};
                    end
                    bytes = st_next[DIR_RX].bytes_moved;
                    arm_dir = DIR_RX;
                    if (st_next[DIR_RX].bytes_left != 16'd0)
                    begin
                        arm_req = 1'b1;
                    end
                    else
                    begin
                        result.transfer_complete = 1'b1;
                        if (cfg.control_endpoint)
                        begin
                            // A control endpoint re-arms its receive buffer when a receive transfer completes.
                            st_next[DIR_RX].buffer_base = cfg.control_rx_address;
                            st_next[DIR_RX].buffer_set  = 1'b1;
                            st_next[DIR_RX].bytes_left  = EP0_RX_LENGTH;
                            st_next[DIR_RX].bytes_moved = '0;
                            st_next[DIR_RX].toggle_bit  = 1'b0;
                            arm_req = 1'b1;
                        end
                    end
                end
                else if (item.token_pid == PID_SETUP)
                begin
                    result.setup_received = cfg.control_endpoint
                                            & (item.byte_count == SETUP_LENGTH);
                end
                else
                begin
                    result.error_code = ERR_BAD_PID;
                end
            end
            FUNC_ABORT:
            begin
                st_next[item.direction] = '0;
                st_next[item.direction].pingpong_index =
                    st_reg[item.direction].pingpong_index
                    ^ st_reg[item.direction].descriptor_owned[0]
                    ^ st_reg[item.direction].descriptor_owned[1];
            end
            default:
            begin
                st_next[0] = st_reg[0];
            end
        endcase

        if (arm_req)
        begin
            arm = try_arm(st_next[arm_dir]);
            result.error_code = arm.err;
            if (arm.err == ERR_NONE)
            begin
                st_next[arm_dir].descriptor_owned[arm.slot] = 1'b1;
                result.arm_valid     = 1'b1;
                result.arm_direction = arm_dir;
                result.arm_slot      = arm.slot;
                result.arm_count     = arm.count;
                result.arm_address   = arm.address;
                result.arm_toggle    = arm.toggle;
            end
        end
        result.bytes_done = bytes;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg[0] <= '0;
            st_reg[1] <= '0;
        end
        else if (step)
        begin
            st_reg[0] <= st_next[0];
            st_reg[1] <= st_next[1];
        end
    end

endmodule

// ----- hdl/usb_endpoint_transfer_sequencer.sv -----
// Top level of the USB endpoint transfer sequencer: stream ports, configuration and staging.
//
//  Channel   Dir  Handshake              Payload
//  s_*       in   s_tvalid / s_tready    s_tuser func, s_tdata item fields
//  m_*       out  m_tvalid / m_tready    m_tdata result fields
//  cfg_*     in   cfg_we                 cfg_index, cfg_data
//
// Each beat is captured in the input register and is worked out in a single pass into
// the result register. Throughput is one beat per cycle while the result is not stalled;
// the endpoint state register is the only loop.
// Reset clears all transfer state and loads the configuration reset values.
// A stalled result holds the input register; s_tready drops only when both are full.
module usb_endpoint_transfer_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bits from 0: direction, slot_code[1:0], length[15:0], data_toggle,
    // buffer_address[31:0], zlp_request, token_pid[3:0], byte_count[9:0], zero fill
    input  logic [uets_pkg::S_DATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // bits from 0: arm_valid, arm_direction, arm_slot, arm_count[6:0], arm_address[31:0],
    // arm_toggle, transfer_complete, bytes_done[15:0], setup_received, error_code[1:0], zero
    output logic [uets_pkg::M_DATA_W-1:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import uets_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t step_res;
    cfg_t    cfg;
    logic    step;

    logic [6:0]  rx_max_packet_reg;
    logic        control_endpoint_reg;
    logic [31:0] control_rx_address_reg;

    assign step     = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, out_res_reg};

    assign cfg.rx_max_packet      = rx_max_packet_reg;
    assign cfg.control_endpoint   = control_endpoint_reg;
    assign cfg.control_rx_address = control_rx_address_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_max_packet_reg      <= MAX_PACKET;
            control_endpoint_reg   <= 1'b0;
            control_rx_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RX_MAX_PACKET:      rx_max_packet_reg      <= cfg_data[6:0];
                CFG_CONTROL_ENDPOINT:   control_endpoint_reg   <= cfg_data[0];
                CFG_CONTROL_RX_ADDRESS: control_rx_address_reg <= cfg_data;
                default:                rx_max_packet_reg      <= rx_max_packet_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= {s_tuser, s_tdata[ITEM_W-1:0]};
        end
        if (step)
        begin
            out_res_reg <= step_res;
        end
    end

    uets_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (step_res)
    );

endmodule

// ----- hdl/uets_checker.sv -----
// Port-level checks on the endpoint transfer sequencer and the bind that attaches them.
module uets_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    import uets_pkg::*;

    // A result waiting on the sink keeps its beat unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Without an armed descriptor every descriptor field reads zero.
    a_arm_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[42:1] == 42'd0)
        else $error("descriptor fields set without an arm");

    // An error never comes with an armed descriptor.
    a_err_no_arm: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[62:61] != ERR_NONE |-> !m_tdata[0])
        else $error("error reported together with an arm");

    // A SETUP notice neither arms nor completes a transfer.
    a_setup_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[60] |-> !m_tdata[0] && !m_tdata[43])
        else $error("setup notice mixed with arm or completion");

    // An armed descriptor never holds more than one packet.
    a_arm_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[9:3] <= MAX_PACKET)
        else $error("armed byte count above the packet size");

endmodule

bind usb_endpoint_transfer_sequencer uets_checker u_uets_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
